@@ design/slpg_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// slpg_pkg: shared definitions for the status LED pattern generator
// Modes, duty selection codes, item structs, timing and divider constants.
// ---------------------------------------------------------------------------
package slpg_pkg;

    localparam int DUTY_MAX_DEFAULT = 1023;

    localparam int DRIVE_W   = 10;
    localparam int MODE_W    = 3;
    localparam int MS_W      = 11;
    localparam int TRI_POS_W = 9;

    // Millisecond thresholds
    localparam logic [MS_W-1:0] MS_LAST         = 11'd1999;
    localparam logic [MS_W-1:0] THINK_PERIOD    = 11'd1000;
    localparam logic [MS_W-1:0] THINK_HALF      = 11'd500;
    localparam logic [MS_W-1:0] SPEAK_PERIOD    = 11'd250;
    localparam logic [MS_W-1:0] SPEAK_HALF      = 11'd125;
    localparam logic [MS_W-1:0] DISCARD_LIMIT   = 11'd600;
    localparam logic [MS_W-1:0] SLOT_MS         = 11'd100;
    localparam int              SPEAK_STEPS     = 7;

    // Both triangles are scaled to a common half period of 500 ms.
    localparam int TRI_HALF = 500;

    // Exact reciprocal of 500 for numerators below 2^LO_W.
    localparam int                LO_W        = 18;
    localparam int                RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP      = 19'd268436;
    localparam int                RECIP_SHIFT = 27;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_INVERT = '0;

    localparam logic OP_MODE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE      = 3'd0,
        MODE_RECORDING = 3'd1,
        MODE_THINKING  = 3'd2,
        MODE_SPEAKING  = 3'd3,
        MODE_NO_NET    = 3'd4,
        MODE_DISCARDED = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        DUTY_HOLD,
        DUTY_ZERO,
        DUTY_FULL,
        DUTY_TRI
    } duty_kind_t;

    typedef struct packed {
        logic              opcode;
        logic [MODE_W-1:0] new_mode;
    } in_item_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_duty;
        logic [MODE_W-1:0]  mode_now;
        logic               auto_idle;
    } out_item_t;

    typedef struct packed {
        duty_kind_t           kind;
        logic [TRI_POS_W-1:0] tri_pos;
        mode_t                mode;
        logic                 auto_idle;
    } slot_t;

endpackage
`default_nettype wire

@@ design/status_led_pattern_generator_unit.sv @@
`default_nettype none
// A result passes through the slot register, the second stage and the result
// register in that order before it is valid.
// Throughput: one item per cycle; the three pipeline registers advance
// together and hold only while a result waits at the output.
// Reset (synchronous, active low) returns the mode to idle, clears the
// in-mode time, the held duty, the inversion register and all valid flags.
// ---------------------------------------------------------------------------
// status_led_pattern_generator_unit: status LED duty generator
// Turns millisecond ticks and mode requests into an LED duty value, with a
// configuration register for active-low drive.
// ---------------------------------------------------------------------------
module status_led_pattern_generator_unit #(
    parameter int DUTY_MAX = slpg_pkg::DUTY_MAX_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire slpg_pkg::in_item_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output slpg_pkg::out_item_t                    m_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [slpg_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [slpg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [slpg_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import slpg_pkg::*;

    logic  en;
    logic  invert_reg;
    logic  slot_valid;
    slot_t slot;
    logic  reg_hit;

    // The whole pipeline moves whenever the result register is free or drained.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_INVERT);
    assign prdata  = reg_hit ? APB_DATA_W'(invert_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg <= 1'b0;
        end else if (psel && penable && pwrite && reg_hit) begin
            invert_reg <= pwdata[0];
        end
    end

    slpg_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .slot_valid (slot_valid),
        .slot       (slot)
    );

    slpg_duty #(
        .DUTY_MAX (DUTY_MAX)
    ) u_duty (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .invert     (invert_reg),
        .slot_valid (slot_valid),
        .slot       (slot),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

@@ design/slpg_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// slpg_ctrl: mode and in-mode time tracking
// Applies each accepted item to the mode state and registers the duty
// selection for the item in the first pipeline stage.
// ---------------------------------------------------------------------------
module slpg_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             s_valid,
    input  wire slpg_pkg::in_item_t s_data,
    output logic                  slot_valid,
    output slpg_pkg::slot_t       slot
);
    import slpg_pkg::*;

    mode_t           mode_reg, mode_next;
    logic [MS_W-1:0] ms_reg, ms_next;
    logic            slot_valid_reg;
    slot_t           slot_reg, slot_next;
    logic            accept;

    logic [MS_W-1:0] phase_1000;
    logic [MS_W-1:0] up_1000;
    logic [2:0]      speak_cnt;
    logic [MS_W-1:0] phase_250;
    logic [MS_W-1:0] up_250;
    logic            no_net_on;
    logic            discard_on;

    assign accept = s_valid && en;

    always_comb begin
        phase_1000 = (ms_reg >= THINK_PERIOD) ? ms_reg - THINK_PERIOD : ms_reg;
        up_1000    = (phase_1000 < THINK_HALF) ? phase_1000 : THINK_PERIOD - phase_1000;

        // Count of whole 250 ms periods; the compares are independent.
        speak_cnt = '0;
        for (int i = 1; i <= SPEAK_STEPS; i++) begin
            if (ms_reg >= MS_W'(i * 250)) begin
                speak_cnt = speak_cnt + 3'd1;
            end
        end
        phase_250 = ms_reg - MS_W'(MS_W'(speak_cnt) * SPEAK_PERIOD);
        up_250    = (phase_250 < SPEAK_HALF) ? phase_250 : SPEAK_PERIOD - phase_250;

        no_net_on  = (ms_reg < SLOT_MS) || (ms_reg > 11'd200 && ms_reg < 11'd300);
        // Even 100 ms slots up to the timeout point.
        discard_on = (ms_reg < SLOT_MS)
                  || (ms_reg >= 11'd200 && ms_reg < 11'd300)
                  || (ms_reg >= 11'd400 && ms_reg < 11'd500)
                  || (ms_reg == DISCARD_LIMIT);
    end

    always_comb begin
        mode_next           = mode_reg;
        ms_next             = ms_reg;
        slot_next.kind      = DUTY_HOLD;
        slot_next.tri_pos   = '0;
        slot_next.auto_idle = 1'b0;
        if (s_data.opcode == OP_MODE) begin
            if (s_data.new_mode <= MODE_DISCARDED && s_data.new_mode != mode_reg) begin
                mode_next = mode_t'(s_data.new_mode);
                ms_next   = '0;
            end
        end else begin
            ms_next = (ms_reg == MS_LAST) ? '0 : ms_reg + 11'd1;
            unique case (mode_reg)
                MODE_IDLE: begin
                    slot_next.kind = DUTY_ZERO;
                end
                MODE_RECORDING: begin
                    slot_next.kind = DUTY_FULL;
                end
                MODE_THINKING: begin
                    slot_next.kind    = DUTY_TRI;
                    slot_next.tri_pos = up_1000[TRI_POS_W-1:0];
                end
                MODE_SPEAKING: begin
                    // Scale the 125 ms half period up to the common 500 ms one.
                    slot_next.kind    = DUTY_TRI;
                    slot_next.tri_pos = {up_250[TRI_POS_W-3:0], 2'b00};
                end
                MODE_NO_NET: begin
                    slot_next.kind = no_net_on ? DUTY_FULL : DUTY_ZERO;
                end
                MODE_DISCARDED: begin
                    if (ms_reg > DISCARD_LIMIT) begin
                        mode_next           = MODE_IDLE;
                        ms_next             = '0;
                        slot_next.auto_idle = 1'b1;
                    end else begin
                        slot_next.kind = discard_on ? DUTY_FULL : DUTY_ZERO;
                    end
                end
                default: begin
                    slot_next.kind = DUTY_HOLD;
                end
            endcase
        end
        slot_next.mode = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            ms_reg         <= '0;
            slot_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg <= mode_next;
                ms_reg   <= ms_next;
            end
            if (en) begin
                slot_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_valid = slot_valid_reg;
    assign slot       = slot_reg;

endmodule
`default_nettype wire

@@ design/slpg_duty.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// slpg_duty: duty evaluation and result register
// Scales the triangle position in two stages, holds the duty between ticks
// and applies the optional inversion.
// ---------------------------------------------------------------------------
module slpg_duty #(
    parameter int DUTY_MAX = slpg_pkg::DUTY_MAX_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             invert,
    input  wire logic             slot_valid,
    input  wire slpg_pkg::slot_t  slot,
    output logic                  m_valid,
    output slpg_pkg::out_item_t   m_data
);
    import slpg_pkg::*;

    localparam int DUTY_W = $clog2(DUTY_MAX + 1);
    localparam int WIDE_W = (DUTY_W > DRIVE_W) ? DUTY_W : DRIVE_W;
    localparam int QUO    = DUTY_MAX / TRI_HALF;
    localparam int REM    = DUTY_MAX % TRI_HALF;
    localparam int PROD_W = LO_W + RECIP_W;

    // Second stage
    logic             valid2_reg;
    duty_kind_t       kind2_reg;
    mode_t            mode2_reg;
    logic             auto2_reg;
    logic [DUTY_W-1:0] hi2_reg, hi2_next;
    logic [LO_W-1:0]   lo2_reg, lo2_next;

    // Result stage
    logic [PROD_W-1:0] recip_prod;
    logic [DUTY_W-1:0] tri_duty;
    logic [DUTY_W-1:0] held_duty_reg, held_duty_next;
    logic [WIDE_W-1:0] drive_wide;
    logic              m_valid_reg;
    out_item_t         out_reg, out_next;

    // pos * DUTY_MAX / 500 split as pos * QUO + (pos * REM) / 500.
    assign hi2_next = DUTY_W'(32'(slot.tri_pos) * 32'(QUO));
    assign lo2_next = LO_W'(32'(slot.tri_pos) * 32'(REM));

    assign recip_prod = PROD_W'(lo2_reg) * PROD_W'(RECIP);
    assign tri_duty   = hi2_reg + DUTY_W'(recip_prod[PROD_W-1:RECIP_SHIFT]);

    always_comb begin
        case (kind2_reg)
            DUTY_ZERO: held_duty_next = '0;
            DUTY_FULL: held_duty_next = DUTY_W'(DUTY_MAX);
            DUTY_TRI:  held_duty_next = tri_duty;
            default:   held_duty_next = held_duty_reg;
        endcase
        drive_wide = invert ? WIDE_W'(DUTY_MAX) - WIDE_W'(held_duty_next)
                            : WIDE_W'(held_duty_next);
        out_next.drive_duty = drive_wide[DRIVE_W-1:0];
        out_next.mode_now   = mode2_reg;
        out_next.auto_idle  = auto2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            held_duty_reg <= '0;
        end else if (en) begin
            valid2_reg  <= slot_valid;
            m_valid_reg <= valid2_reg;
            if (valid2_reg) begin
                held_duty_reg <= held_duty_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind2_reg <= slot.kind;
            mode2_reg <= slot.mode;
            auto2_reg <= slot.auto_idle;
            hi2_reg   <= hi2_next;
            lo2_reg   <= lo2_next;
            out_reg   <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

@@ tb/sv/tb_status_led_pattern_generator_unit.sv @@
// ---------------------------------------------------------------------------
// tb_status_led_pattern_generator_unit: self-checking bench for the LED unit
// Sends ticks and mode requests through the input channel and predicts the
// duty, mode and auto-idle flag of every result. The bench runs in four phases
// with different amounts of sender idling and receiver stalling. The inversion
// register is written and read back over the APB port between phases.
// ---------------------------------------------------------------------------
module tb_status_led_pattern_generator_unit;
    import slpg_pkg::*;

    localparam int unsigned FULL_SCALE = DUTY_MAX_DEFAULT;
    localparam int unsigned THINK_MS   = 1000;
    localparam int unsigned SPEAK_MS   = 250;
    localparam int unsigned WRAP_MS    = 2000;
    localparam int unsigned DISCARD_MS = 600;
    localparam int unsigned FLASH_MS   = 100;
    localparam int unsigned BLINK_A_MS = 100;
    localparam int unsigned BLINK_B_LO = 200;
    localparam int unsigned BLINK_B_HI = 300;

    localparam logic              OP_TICK     = 1'b0;
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
    localparam logic [APB_ADDR_W-1:0] INVERT_ADDR = {REG_INVERT, 2'b00};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    in_item_t              s_data   = '0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    out_item_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    mode_t           led_mode     = MODE_IDLE;
    logic [MS_W-1:0] led_ms       = '0;
    int unsigned     led_held     = 0;
    logic            led_inverted = 1'b0;

    in_item_t  item_queue[$];
    out_item_t led_due[$];
    logic      in_taken = 1'b0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        mismatch_count = 0;
    out_item_t due;

    status_led_pattern_generator_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned triangle_duty(int unsigned t, int unsigned period);
        int unsigned pos;
        int unsigned half;
        int unsigned up;
        pos  = t % period;
        half = period / 2;
        up   = (pos < half) ? pos : period - pos;
        return (up * FULL_SCALE) / half;
    endfunction

    // Advances the predicted LED state by one item and returns its result.
    function automatic out_item_t led_step(in_item_t it);
        out_item_t   r;
        int unsigned t;
        logic        timed_out;
        int unsigned drive;
        timed_out = 1'b0;
        if (it.opcode == OP_MODE) begin
            if (it.new_mode <= MODE_DISCARDED && it.new_mode != led_mode) begin
                led_mode = mode_t'(it.new_mode);
                led_ms   = '0;
            end
        end else begin
            t = led_ms;
            case (led_mode)
                MODE_IDLE:      led_held = 0;
                MODE_RECORDING: led_held = FULL_SCALE;
                MODE_THINKING:  led_held = triangle_duty(t, THINK_MS);
                MODE_SPEAKING:  led_held = triangle_duty(t, SPEAK_MS);
                MODE_NO_NET: begin
                    led_held = (t < BLINK_A_MS || (t > BLINK_B_LO && t < BLINK_B_HI))
                               ? FULL_SCALE : 0;
                end
                default: begin
                    if (t > DISCARD_MS) begin
                        led_mode  = MODE_IDLE;
                        led_ms    = '0;
                        timed_out = 1'b1;
                    end else begin
                        led_held = (((t / FLASH_MS) % 2) == 0) ? FULL_SCALE : 0;
                    end
                end
            endcase
            // The time-out restarts the clock itself, so it does not advance.
            if (!timed_out) begin
                led_ms = MS_W'((int'(led_ms) + 1) % WRAP_MS);
            end
        end
        drive        = led_inverted ? FULL_SCALE - led_held : led_held;
        r.drive_duty = drive[DRIVE_W-1:0];
        r.mode_now   = led_mode;
        r.auto_idle  = timed_out;
        return r;
    endfunction

    // Driver: a new item is offered only once the previous one has gone.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (!s_valid || in_taken) begin
            if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= item_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: the result is checked before the new item is predicted.
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (led_due.size() == 0) begin
                    $error("result with no item outstanding: duty %0d mode %0d auto_idle %0d",
                           m_data.drive_duty, m_data.mode_now, m_data.auto_idle);
                    mismatch_count++;
                end else begin
                    due = led_due.pop_front();
                    if (m_data.drive_duty !== due.drive_duty) begin
                        $error("drive_duty: expected %0d, got %0d",
                               due.drive_duty, m_data.drive_duty);
                        mismatch_count++;
                    end
                    if (m_data.mode_now !== due.mode_now) begin
                        $error("mode_now: expected %0d, got %0d", due.mode_now, m_data.mode_now);
                        mismatch_count++;
                    end
                    if (m_data.auto_idle !== due.auto_idle) begin
                        $error("auto_idle: expected %0d, got %0d",
                               due.auto_idle, m_data.auto_idle);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                led_due.push_back(led_step(s_data));
            end
        end
    end

    task automatic push_ticks(int n);
        in_item_t it;
        repeat (n) begin
            it.opcode   = OP_TICK;
            it.new_mode = MODE_W'($urandom_range(7));
            item_queue.push_back(it);
        end
    endtask

    task automatic push_mode(logic [MODE_W-1:0] m);
        in_item_t it;
        it.opcode   = OP_MODE;
        it.new_mode = m;
        item_queue.push_back(it);
    endtask

    // Writes the inversion register, then reads it back.
    task automatic write_invert(logic v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INVERT_ADDR;
        pwdata  <= APB_DATA_W'(v);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        led_inverted = v;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(v)) begin
            $error("invert_output: expected %0d, got %0d", v, prdata);
            mismatch_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly a mode request followed by a run of ticks; the rest is noise,
    // including requests for the spare mode codes.
    task automatic push_random(int target);
        int       pushed;
        int       run;
        in_item_t it;
        pushed = 0;
        while (pushed < target) begin
            if ($urandom_range(99) < 15) begin
                it.opcode   = 1'($urandom_range(1));
                it.new_mode = MODE_W'($urandom_range(7));
                item_queue.push_back(it);
                pushed++;
            end else begin
                run = ($urandom_range(9) == 0) ? $urandom_range(100, 320)
                                               : $urandom_range(1, 30);
                push_mode(MODE_W'($urandom_range(5)));
                push_ticks(run);
                pushed += run + 1;
            end
        end
    endtask

    task automatic drain();
        while (item_queue.size() != 0 || s_valid || led_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            write_invert(1'(phase % 2));

            if (phase == 0) begin
                // Directed: every mode, repeated and spare requests.
                push_ticks(2);
                push_mode(MODE_RECORDING);
                push_ticks(1);
                push_mode(MODE_RECORDING);
                push_ticks(1);
                push_mode(MODE_SPARE6);
                push_mode(MODE_SPARE7);
                push_ticks(1);
                push_mode(MODE_THINKING);
                push_ticks(2);
                push_mode(MODE_SPEAKING);
                push_ticks(2);
                push_mode(MODE_NO_NET);
                push_ticks(1);
                push_mode(MODE_DISCARDED);
                push_ticks(1);
                push_mode(MODE_IDLE);
                push_ticks(1);
                push_mode(MODE_IDLE);
                // A long thinking run wraps the millisecond count.
                push_mode(MODE_THINKING);
                push_ticks(WRAP_MS + 3);
            end
            if (phase == 0 || phase == 2) begin
                // Discarded mode held long enough to time out to idle.
                push_mode(MODE_DISCARDED);
                push_ticks(DISCARD_MS + $urandom_range(3, 20));
            end
            push_random(125);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
design/slpg_pkg.sv
design/slpg_ctrl.sv
design/slpg_duty.sv
design/status_led_pattern_generator_unit.sv
tb/sv/tb_status_led_pattern_generator_unit.sv
